@@ design/swiv_pkg.sv @@
package swiv_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_WINDOW_DEF = 64;
    localparam int ID_BITS_DEF    = 10;
    localparam int SCORE_BITS_DEF = 16;

    // Configuration port layout.
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_VOTES_NEEDED  = 1'b1;

    localparam logic [CFG_W-1:0] WINDOW_LENGTH_RST = 7'd30;
    localparam logic [CFG_W-1:0] VOTES_NEEDED_RST  = 7'd10;

    // Commands shared by every cell of the chain.
    typedef struct packed {
        logic push;
        logic rotate;
    } t_cell_ctl;

    // Per-cell position decisions made by the top level.
    typedef struct packed {
        logic keep;
        logic wrap;
    } t_cell_sel;

endpackage

@@ design/swiv_cell.sv @@
module swiv_cell #(
    parameter int ID_BITS    = swiv_pkg::ID_BITS_DEF,
    parameter int SCORE_BITS = swiv_pkg::SCORE_BITS_DEF,
    parameter int CNT_W      = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  swiv_pkg::t_cell_ctl   i_ctl,
    input  swiv_pkg::t_cell_sel   i_sel,
    input  logic                  i_push_hit,
    input  logic [ID_BITS-1:0]    i_push_id,
    input  logic [SCORE_BITS-1:0] i_push_score,
    input  logic                  i_nxt_hit,
    input  logic [ID_BITS-1:0]    i_nxt_id,
    input  logic [SCORE_BITS-1:0] i_nxt_score,
    input  logic [CNT_W-1:0]      i_nxt_cnt,
    input  logic [SCORE_BITS-1:0] i_nxt_mx,
    input  logic                  i_bc_hit,
    input  logic [ID_BITS-1:0]    i_bc_id,
    input  logic [SCORE_BITS-1:0] i_bc_score,
    input  logic [CNT_W-1:0]      i_bc_cnt,
    input  logic [SCORE_BITS-1:0] i_bc_mx,
    output logic                  o_hit,
    output logic [ID_BITS-1:0]    o_id,
    output logic [SCORE_BITS-1:0] o_score,
    output logic [CNT_W-1:0]      o_cnt,
    output logic [SCORE_BITS-1:0] o_mx
);

    logic                  r_hit;
    logic [ID_BITS-1:0]    r_id;
    logic [SCORE_BITS-1:0] r_score;
    logic [CNT_W-1:0]      r_cnt;
    logic [SCORE_BITS-1:0] r_mx;

    logic                  w_src_hit;
    logic [ID_BITS-1:0]    w_src_id;
    logic [SCORE_BITS-1:0] w_src_score;
    logic [CNT_W-1:0]      w_src_cnt;
    logic [SCORE_BITS-1:0] w_src_mx;
    logic                  w_match;
    logic [CNT_W-1:0]      n_cnt;
    logic [SCORE_BITS-1:0] n_mx;

    // The tail of the active window takes the head entry so the window closes into a ring.
    always_comb begin
        if (i_sel.wrap) begin
            w_src_hit   = i_bc_hit;
            w_src_id    = i_bc_id;
            w_src_score = i_bc_score;
            w_src_cnt   = i_bc_cnt;
            w_src_mx    = i_bc_mx;
        end else begin
            w_src_hit   = i_nxt_hit;
            w_src_id    = i_nxt_id;
            w_src_score = i_nxt_score;
            w_src_cnt   = i_nxt_cnt;
            w_src_mx    = i_nxt_mx;
        end
        w_match = i_bc_hit & w_src_hit & (w_src_id == i_bc_id);
        n_cnt   = w_match ? w_src_cnt + CNT_W'(1) : w_src_cnt;
        n_mx    = (w_match && (i_bc_score > w_src_mx)) ? i_bc_score : w_src_mx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctl.push) begin
            r_hit <= i_push_hit & i_sel.keep;
        end else if (i_ctl.rotate) begin
            r_hit <= w_src_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_id    <= i_push_id;
            r_score <= i_push_score;
            r_cnt   <= '0;
            r_mx    <= '0;
        end else if (i_ctl.rotate) begin
            r_id    <= w_src_id;
            r_score <= w_src_score;
            r_cnt   <= n_cnt;
            r_mx    <= n_mx;
        end
    end

    assign o_hit   = r_hit;
    assign o_id    = r_id;
    assign o_score = r_score;
    assign o_cnt   = r_cnt;
    assign o_mx    = r_mx;

endmodule

@@ design/sliding_window_identity_vote.sv @@
// Sliding-window identity vote for one face track. Each input item is one recognition
// result (identity and similarity, or a miss); it is pushed into a window of the most
// recent window_length results, newest in cell 0 of a chain of cells. Until the track
// is confirmed, a vote runs over the window: the chain rotates once around the filled
// cells while the head entry is broadcast to every cell, so each entry gathers the count
// and maximum similarity of its identity among newer entries. The head's totals stream
// into a selector that keeps the highest count, then the higher similarity, then the
// older entry. Once the winner's count reaches votes_needed the identity and score are
// held until an item with new_track set. The vote for an item is a single rotation lap of
// the cell chain over fill, the number of entries in the window after the push (at most
// the window length); an item on a confirmed track skips the lap.
// Configuration writes belong only to idle periods. The result goes to an output
// register, so the next item is taken while the previous result waits.
module sliding_window_identity_vote #(
    parameter int MAX_WINDOW = swiv_pkg::MAX_WINDOW_DEF,
    parameter int ID_BITS    = swiv_pkg::ID_BITS_DEF,
    parameter int SCORE_BITS = swiv_pkg::SCORE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write port.
    input  logic                           i_cfg_we,
    input  logic [swiv_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [swiv_pkg::CFG_W-1:0]     i_cfg_data,
    // Input channel.
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_new_track,
    input  logic                           i_has_result,
    input  logic [ID_BITS-1:0]             i_name_id,
    input  logic [SCORE_BITS-1:0]          i_similarity,
    // Output channel.
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_is_confirmed,
    output logic [ID_BITS-1:0]             o_confirmed_id,
    output logic [SCORE_BITS-1:0]          o_confirmed_score,
    output logic [6:0]                     o_winner_votes
);

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W = (CNT_W > swiv_pkg::CFG_W) ? CNT_W : swiv_pkg::CFG_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_VOTE = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [swiv_pkg::CFG_W-1:0] r_win_len;
    logic [swiv_pkg::CFG_W-1:0] r_votes;

    // Track state.
    logic [CNT_W-1:0]      r_fill;
    logic [CNT_W-1:0]      r_left;
    logic                  r_conf;
    logic [ID_BITS-1:0]    r_held_id;
    logic [SCORE_BITS-1:0] r_held_score;

    // Running winner of the current vote.
    logic [CNT_W-1:0]      r_best_cnt;
    logic [ID_BITS-1:0]    r_best_id;
    logic [SCORE_BITS-1:0] r_best_mx;

    // Output register.
    logic                  r_out_valid;
    logic                  r_out_conf;
    logic [ID_BITS-1:0]    r_out_id;
    logic [SCORE_BITS-1:0] r_out_score;
    logic [6:0]            r_out_votes;

    // Cell chain wiring.
    logic                  w_hit   [MAX_WINDOW];
    logic [ID_BITS-1:0]    w_id    [MAX_WINDOW];
    logic [SCORE_BITS-1:0] w_score [MAX_WINDOW];
    logic [CNT_W-1:0]      w_cnt   [MAX_WINDOW];
    logic [SCORE_BITS-1:0] w_mx    [MAX_WINDOW];

    swiv_pkg::t_cell_ctl   w_ctl;
    logic                  w_in_acc;
    logic                  w_out_free;
    logic [CMP_W-1:0]      w_wl;
    logic [CMP_W-1:0]      w_need;
    logic [CNT_W-1:0]      w_eff;
    logic [CNT_W-1:0]      w_base;
    logic [CNT_W:0]        w_sum;
    logic [CNT_W-1:0]      w_fill_new;
    logic [CNT_W-1:0]      w_fill_m1;
    logic [CNT_W-1:0]      w_head_cnt;
    logic [SCORE_BITS-1:0] w_head_mx;
    logic                  w_head_wins;
    logic                  w_win;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len <= swiv_pkg::WINDOW_LENGTH_RST;
            r_votes   <= swiv_pkg::VOTES_NEEDED_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                swiv_pkg::REG_WINDOW_LENGTH: r_win_len <= i_cfg_data;
                swiv_pkg::REG_VOTES_NEEDED:  r_votes   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A window length of zero acts as one; beyond the chain it saturates.
    // Votes needed of zero acts as one.
    always_comb begin
        w_wl = CMP_W'(r_win_len);
        if (w_wl == '0) begin
            w_eff = CNT_W'(1);
        end else if (w_wl > CMP_W'(MAX_WINDOW)) begin
            w_eff = CNT_W'(MAX_WINDOW);
        end else begin
            w_eff = CNT_W'(w_wl);
        end
        w_need = (r_votes == '0) ? CMP_W'(1) : CMP_W'(r_votes);
    end

    // Fill after the push: oldest entries fall off so the window never exceeds its length.
    always_comb begin
        w_base     = i_new_track ? '0 : r_fill;
        w_sum      = {1'b0, w_base} + (CNT_W + 1)'(1);
        w_fill_new = (w_sum > {1'b0, w_eff}) ? w_eff : CNT_W'(w_sum);
        w_fill_m1  = r_fill - CNT_W'(1);
    end

    assign w_ctl.push   = w_in_acc;
    assign w_ctl.rotate = (r_state == S_VOTE);

    genvar g;
    generate
        for (g = 0; g < MAX_WINDOW; g++) begin : g_cell
            swiv_pkg::t_cell_sel   w_sel;
            logic                  w_push_hit;
            logic [ID_BITS-1:0]    w_push_id;
            logic [SCORE_BITS-1:0] w_push_score;
            logic                  w_nxt_hit;
            logic [ID_BITS-1:0]    w_nxt_id;
            logic [SCORE_BITS-1:0] w_nxt_score;
            logic [CNT_W-1:0]      w_nxt_cnt;
            logic [SCORE_BITS-1:0] w_nxt_mx;

            assign w_sel.keep = (CNT_W'(g) < w_eff);
            assign w_sel.wrap = (CNT_W'(g) == w_fill_m1);

            // The new item enters at cell 0; a new track drops everything older.
            if (g == 0) begin : g_head
                assign w_push_hit   = i_has_result;
                assign w_push_id    = i_name_id;
                assign w_push_score = i_similarity;
            end else begin : g_body
                assign w_push_hit   = w_hit[g-1] & ~i_new_track;
                assign w_push_id    = w_id[g-1];
                assign w_push_score = w_score[g-1];
            end

            if (g == MAX_WINDOW - 1) begin : g_last
                assign w_nxt_hit   = 1'b0;
                assign w_nxt_id    = '0;
                assign w_nxt_score = '0;
                assign w_nxt_cnt   = '0;
                assign w_nxt_mx    = '0;
            end else begin : g_mid
                assign w_nxt_hit   = w_hit[g+1];
                assign w_nxt_id    = w_id[g+1];
                assign w_nxt_score = w_score[g+1];
                assign w_nxt_cnt   = w_cnt[g+1];
                assign w_nxt_mx    = w_mx[g+1];
            end

            swiv_cell #(
                .ID_BITS    (ID_BITS),
                .SCORE_BITS (SCORE_BITS),
                .CNT_W      (CNT_W)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_sel        (w_sel),
                .i_push_hit   (w_push_hit),
                .i_push_id    (w_push_id),
                .i_push_score (w_push_score),
                .i_nxt_hit    (w_nxt_hit),
                .i_nxt_id     (w_nxt_id),
                .i_nxt_score  (w_nxt_score),
                .i_nxt_cnt    (w_nxt_cnt),
                .i_nxt_mx     (w_nxt_mx),
                .i_bc_hit     (w_hit[0]),
                .i_bc_id      (w_id[0]),
                .i_bc_score   (w_score[0]),
                .i_bc_cnt     (w_cnt[0]),
                .i_bc_mx      (w_mx[0]),
                .o_hit        (w_hit[g]),
                .o_id         (w_id[g]),
                .o_score      (w_score[g]),
                .o_cnt        (w_cnt[g]),
                .o_mx         (w_mx[g])
            );
        end
    endgenerate

    // The head has already seen every newer entry; adding itself completes its totals.
    // Entries arrive newest first, and a newer occurrence of an identity always scores
    // below its oldest occurrence, so only oldest occurrences can win. An equal result
    // replaces the holder, so the oldest entry wins a full tie.
    always_comb begin
        w_head_cnt  = w_cnt[0] + CNT_W'(1);
        w_head_mx   = (w_score[0] > w_mx[0]) ? w_score[0] : w_mx[0];
        w_head_wins = w_hit[0] &&
                      ((w_head_cnt > r_best_cnt) ||
                       ((w_head_cnt == r_best_cnt) && (w_head_mx >= r_best_mx)));
        w_win       = !r_conf && (CMP_W'(r_best_cnt) >= w_need);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = (r_conf && !i_new_track) ? S_OUT : S_VOTE;
                end
            end
            S_VOTE: begin
                if (r_left == CNT_W'(1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fill       <= '0;
            r_conf       <= 1'b0;
            r_held_id    <= '0;
            r_held_score <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                r_fill <= w_fill_new;
                if (i_new_track) begin
                    r_conf       <= 1'b0;
                    r_held_id    <= '0;
                    r_held_score <= '0;
                end
            end
            if ((r_state == S_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
                if (w_win) begin
                    r_conf       <= 1'b1;
                    r_held_id    <= r_best_id;
                    r_held_score <= r_best_mx;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Lap counter and running winner.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_left     <= w_fill_new;
            r_best_cnt <= '0;
            r_best_id  <= '0;
            r_best_mx  <= '0;
        end else if (r_state == S_VOTE) begin
            r_left <= r_left - CNT_W'(1);
            if (w_head_wins) begin
                r_best_cnt <= w_head_cnt;
                r_best_id  <= w_id[0];
                r_best_mx  <= w_head_mx;
            end
        end
    end

    // Identity and score fields: the held values once confirmed, zero otherwise.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && w_out_free) begin
            r_out_conf  <= r_conf | w_win;
            r_out_votes <= 7'(r_best_cnt);
            if (r_conf) begin
                r_out_id    <= r_held_id;
                r_out_score <= r_held_score;
            end else if (w_win) begin
                r_out_id    <= r_best_id;
                r_out_score <= r_best_mx;
            end else begin
                r_out_id    <= '0;
                r_out_score <= '0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_is_confirmed    = r_out_conf;
    assign o_confirmed_id    = r_out_id;
    assign o_confirmed_score = r_out_score;
    assign o_winner_votes    = r_out_votes;

    // The lap counter never runs out while the chain rotates.
    a_lap_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_VOTE) |-> (r_left != '0))
        else $error("vote lap running with no cycles left");

    // Confirmation is kept until an item opens a new track.
    a_conf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_conf && !(w_in_acc && i_new_track)) |=> r_conf)
        else $error("confirmation lost without a new track");

    // An unconfirmed result carries no identity and no score.
    a_unconf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_is_confirmed) |-> ((o_confirmed_id == '0) &&
                                              (o_confirmed_score == '0)))
        else $error("unconfirmed result carries held values");

    // The leading count can never exceed the entries in the window.
    a_best_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_VOTE) |-> (r_best_cnt <= r_fill))
        else $error("winner count exceeds window fill");

endmodule
